>>> hw/rtl/crci_pkg.sv
package crci_pkg;

  // field and datapath widths
  localparam int COORD_W   = 16;
  localparam int N_W       = 7;
  localparam int MAX_PPS   = 64;
  localparam int T_W       = 31;
  localparam int ROOT_W    = 29;
  localparam int SQ_W      = 34;
  localparam int SQV_W     = 2 * ROOT_W;
  localparam int SQR_W     = ROOT_W + 4;
  localparam int MP_W      = T_W + 1 + COORD_W;
  localparam int ACC_W     = MP_W + 2;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EN  = 2'd1;

  // one segment job: the four control points and the run length
  typedef struct packed {
    logic [3:0][COORD_W-1:0] px;
    logic [3:0][COORD_W-1:0] py;
    logic [N_W-1:0]          n;
  } crci_job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } crci_qstat_t;

  // saturate a wide signed value to a coordinate
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    lo = $signed({{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

>>> hw/rtl/crci_queue.sv
module crci_queue import crci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  crci_job_t   wr_job,
  input  logic        pop,
  output crci_job_t   rd_job,
  output crci_qstat_t stat
);

  crci_job_t  ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign rd_job     = ent_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // two-entry job queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_job;
    end
  end

endmodule

>>> hw/rtl/crci_front.sv
module crci_front import crci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_point_x,
  input  logic [COORD_W-1:0]   in_point_y,
  input  logic                 in_new_curve,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [N_W-1:0]       cfg_data,
  input  crci_qstat_t          q_stat,
  output logic                 q_push,
  output crci_job_t            q_job
);

  logic [COORD_W-1:0] wx_r [3];
  logic [COORD_W-1:0] wy_r [3];
  logic [1:0]         held_r;
  logic [N_W-1:0]     pps_r;
  logic               en_r;
  logic [1:0]         held_eff;
  logic               acc;
  logic [N_W-1:0]     n_cl;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign held_eff = in_new_curve ? 2'd0 : held_r;

  // clamp the run length
  always_comb begin
    if (pps_r < N_W'(2)) begin
      n_cl = N_W'(2);
    end else if (pps_r > N_W'(MAX_PPS)) begin
      n_cl = N_W'(MAX_PPS);
    end else begin
      n_cl = pps_r;
    end
  end

  // job when the window is full and interpolation is on
  assign q_push = acc && (held_eff == 2'd3) && en_r;
  always_comb begin
    q_job.px = {in_point_x, wx_r[2], wx_r[1], wx_r[0]};
    q_job.py = {in_point_y, wy_r[2], wy_r[1], wy_r[0]};
    q_job.n  = n_cl;
  end

  // configuration and window count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      pps_r  <= N_W'(8);
      en_r   <= 1'b1;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_PPS: pps_r <= cfg_data;
          REG_EN:  en_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (acc) begin
        held_r <= (held_eff == 2'd3) ? 2'd3 : held_eff + 2'd1;
      end
    end
  end

  // point window, oldest first
  always_ff @(posedge clk) begin
    if (acc) begin
      wx_r[0] <= wx_r[1];
      wy_r[0] <= wy_r[1];
      wx_r[1] <= wx_r[2];
      wy_r[1] <= wy_r[2];
      wx_r[2] <= in_point_x;
      wy_r[2] <= in_point_y;
    end
  end

endmodule

>>> hw/rtl/crci_div.sv
module crci_div import crci_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic [T_W-1:0]          den,
  input  logic                    rnd,
  output logic                    done,
  output logic signed [ACC_W-1:0] quo
);

  localparam int CNT_W = $clog2(ACC_W);

  logic                    run_r;
  logic                    fin_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ACC_W-1:0]        mag_r;
  logic [T_W:0]            rem_r;
  logic [ACC_W-1:0]        q_r;
  logic                    neg_r;
  logic                    rnd_r;
  logic [T_W-1:0]          den_r;
  logic signed [ACC_W-1:0] quo_r;
  logic [T_W:0]            rem_sh;
  logic                    qbit;
  logic signed [ACC_W-1:0] qf;
  logic [T_W-1:0]          rf;
  logic [T_W:0]            two_r;

  assign done = done_r;
  assign quo  = quo_r;

  // one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_r[T_W-1:0], mag_r[ACC_W-1]};
    qbit   = (rem_sh >= {1'b0, den_r});
  end

  // floor correction for negative numerators, then round half to even when rnd is set
  always_comb begin
    if (neg_r && rem_r[T_W-1:0] != '0) begin
      qf = -$signed(q_r + ACC_W'(1));
      rf = den_r - rem_r[T_W-1:0];
    end else if (neg_r) begin
      qf = -$signed(q_r);
      rf = '0;
    end else begin
      qf = $signed(q_r);
      rf = rem_r[T_W-1:0];
    end
    two_r = {rf, 1'b0};
    if (rnd_r && (two_r > {1'b0, den_r} || (two_r == {1'b0, den_r} && qf[0]))) begin
      qf = qf + ACC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        mag_r <= num[ACC_W-1] ? ACC_W'(-num) : num;
        rem_r <= '0;
        q_r   <= '0;
        neg_r <= num[ACC_W-1];
        rnd_r <= rnd;
        den_r <= den;
      end else if (run_r) begin
        rem_r <= qbit ? rem_sh - {1'b0, den_r} : rem_sh;
        q_r   <= {q_r[ACC_W-2:0], qbit};
        mag_r <= {mag_r[ACC_W-2:0], 1'b0};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACC_W-1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        quo_r  <= qf;
      end
    end
  end

endmodule

>>> hw/rtl/crci_back.sv
module crci_back import crci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  crci_qstat_t        q_stat,
  input  crci_job_t          q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic               out_last_of_run,
  output logic               out_degenerate
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHX   = 4'd1;
  localparam logic [3:0] S_CHY   = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_CHEND = 4'd4;
  localparam logic [3:0] S_SMP   = 4'd5;
  localparam logic [3:0] S_TW    = 4'd6;
  localparam logic [3:0] S_A     = 4'd7;
  localparam logic [3:0] S_B     = 4'd8;
  localparam logic [3:0] S_W     = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam int SC_W = $clog2(ROOT_W);

  logic [3:0]                state_r;
  crci_job_t                 job_r;
  logic [1:0]                ch_r;
  logic [SQ_W-1:0]           sq_r;
  logic [SQV_W-1:0]          sv_r;
  logic [SQR_W-1:0]          srem_r;
  logic [ROOT_W-1:0]         sroot_r;
  logic [SC_W-1:0]           scnt_r;
  logic [T_W-1:0]            kn1_r;
  logic [T_W-1:0]            kn2_r;
  logic [T_W-1:0]            kn3_r;
  logic [N_W-1:0]            i_r;
  logic [T_W-1:0]            t_r;
  logic [2:0]                st_r;
  logic                      crd_r;
  logic                      deg_r;
  logic signed [MP_W-1:0]    m_r;
  logic [COORD_W-1:0]        rx_r [6];
  logic [COORD_W-1:0]        ry_r [6];
  logic                      ov_r;
  logic [COORD_W-1:0]        ox_r;
  logic [COORD_W-1:0]        oy_r;
  logic                      ol_r;
  logic                      od_r;

  logic signed [COORD_W:0]   da;
  logic signed [COORD_W:0]   db;
  logic signed [2*COORD_W+1:0] dsq;
  logic [SQ_W-1:0]           ssum;
  logic [SQR_W-1:0]          srem_sh;
  logic [SQR_W-1:0]          strial;
  logic [T_W-1:0]            ti_v;
  logic [T_W-1:0]            tj_v;
  logic [COORD_W-1:0]        lx;
  logic [COORD_W-1:0]        ly;
  logic [COORD_W-1:0]        rx;
  logic [COORD_W-1:0]        ry;
  logic signed [COORD_W-1:0] lc;
  logic signed [COORD_W-1:0] rc;
  logic [T_W-1:0]            den;
  logic signed [T_W:0]       dl;
  logic signed [T_W:0]       dr;
  logic signed [MP_W-1:0]    mp;
  logic signed [ACC_W-1:0]   acc;
  logic [T_W+N_W-1:0]        kprod;
  logic                      div_start;
  logic signed [ACC_W-1:0]   div_num;
  logic [T_W-1:0]            div_den;
  logic                      div_rnd;
  logic                      div_done;
  logic signed [ACC_W-1:0]   div_quo;
  logic                      out_free;
  logic                      out_load;

  assign out_valid       = ov_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_last_of_run = ol_r;
  assign out_degenerate  = od_r;
  assign out_free        = !ov_r || out_ready;
  assign out_load        = (state_r == S_OUT) && out_free;
  assign q_pop           = (state_r == S_IDLE) && !q_stat.empty;

  // chord endpoints
  always_comb begin
    case (ch_r)
      2'd0: begin
        da = $signed({job_r.px[1][COORD_W-1], job_r.px[1]})
           - $signed({job_r.px[0][COORD_W-1], job_r.px[0]});
        db = $signed({job_r.py[1][COORD_W-1], job_r.py[1]})
           - $signed({job_r.py[0][COORD_W-1], job_r.py[0]});
      end
      2'd1: begin
        da = $signed({job_r.px[2][COORD_W-1], job_r.px[2]})
           - $signed({job_r.px[1][COORD_W-1], job_r.px[1]});
        db = $signed({job_r.py[2][COORD_W-1], job_r.py[2]})
           - $signed({job_r.py[1][COORD_W-1], job_r.py[1]});
      end
      default: begin
        da = $signed({job_r.px[3][COORD_W-1], job_r.px[3]})
           - $signed({job_r.px[2][COORD_W-1], job_r.px[2]});
        db = $signed({job_r.py[3][COORD_W-1], job_r.py[3]})
           - $signed({job_r.py[2][COORD_W-1], job_r.py[2]});
      end
    endcase
    dsq  = (state_r == S_CHX) ? da * da : db * db;
    ssum = sq_r + dsq[SQ_W-1:0];
  end

  // square root, one bit pair a cycle
  assign srem_sh = {srem_r[SQR_W-3:0], sv_r[SQV_W-1 -: 2]};
  assign strial  = {2'b00, sroot_r, 2'b01};

  // knots and points of each pyramid stage
  always_comb begin
    case (st_r)
      3'd0: begin
        ti_v = '0;    tj_v = kn1_r;
        lx = job_r.px[0]; ly = job_r.py[0]; rx = job_r.px[1]; ry = job_r.py[1];
      end
      3'd1: begin
        ti_v = kn1_r; tj_v = kn2_r;
        lx = job_r.px[1]; ly = job_r.py[1]; rx = job_r.px[2]; ry = job_r.py[2];
      end
      3'd2: begin
        ti_v = kn2_r; tj_v = kn3_r;
        lx = job_r.px[2]; ly = job_r.py[2]; rx = job_r.px[3]; ry = job_r.py[3];
      end
      3'd3: begin
        ti_v = '0;    tj_v = kn2_r;
        lx = rx_r[0]; ly = ry_r[0]; rx = rx_r[1]; ry = ry_r[1];
      end
      3'd4: begin
        ti_v = kn1_r; tj_v = kn3_r;
        lx = rx_r[1]; ly = ry_r[1]; rx = rx_r[2]; ry = ry_r[2];
      end
      default: begin
        ti_v = kn1_r; tj_v = kn2_r;
        lx = rx_r[3]; ly = ry_r[3]; rx = rx_r[4]; ry = ry_r[4];
      end
    endcase
    lc  = $signed(crd_r ? ly : lx);
    rc  = $signed(crd_r ? ry : rx);
    den = tj_v - ti_v;
    dl  = $signed({1'b0, tj_v}) - $signed({1'b0, t_r});
    dr  = $signed({1'b0, t_r}) - $signed({1'b0, ti_v});
    mp  = (state_r == S_A) ? dl * lc : dr * rc;
    acc = $signed({{(ACC_W-MP_W){m_r[MP_W-1]}}, m_r})
        + $signed({{(ACC_W-MP_W){mp[MP_W-1]}}, mp});
  end

  // divider requests: sample knot in floor mode, stages rounded
  assign kprod = (kn2_r - kn1_r) * i_r;
  always_comb begin
    div_start = 1'b0;
    div_num   = acc;
    div_den   = den;
    div_rnd   = 1'b1;
    if (state_r == S_SMP) begin
      div_start = 1'b1;
      div_num   = $signed({{(ACC_W-T_W-N_W){1'b0}}, kprod});
      div_den   = T_W'(job_r.n - N_W'(1));
      div_rnd   = 1'b0;
    end else if (state_r == S_B) begin
      div_start = 1'b1;
    end
  end

  crci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .rnd   (div_rnd),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && out_ready && !out_load) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            job_r   <= q_job;
            ch_r    <= 2'd0;
            state_r <= S_CHX;
          end
        end
        S_CHX: begin
          sq_r    <= dsq[SQ_W-1:0];
          state_r <= S_CHY;
        end
        S_CHY: begin
          sv_r    <= {ssum, {(SQV_W-SQ_W){1'b0}}};
          srem_r  <= '0;
          sroot_r <= '0;
          scnt_r  <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (srem_sh >= strial) begin
            srem_r  <= srem_sh - strial;
            sroot_r <= {sroot_r[ROOT_W-2:0], 1'b1};
          end else begin
            srem_r  <= srem_sh;
            sroot_r <= {sroot_r[ROOT_W-2:0], 1'b0};
          end
          sv_r   <= {sv_r[SQV_W-3:0], 2'b00};
          scnt_r <= scnt_r + SC_W'(1);
          if (scnt_r == SC_W'(ROOT_W-1)) begin
            state_r <= S_CHEND;
          end
        end
        S_CHEND: begin
          case (ch_r)
            2'd0:    kn1_r <= T_W'(sroot_r);
            2'd1:    kn2_r <= kn1_r + T_W'(sroot_r);
            default: kn3_r <= kn2_r + T_W'(sroot_r);
          endcase
          if (ch_r == 2'd2) begin
            i_r     <= '0;
            state_r <= S_SMP;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_CHX;
          end
        end
        S_SMP: begin
          state_r <= S_TW;
        end
        S_TW: begin
          if (div_done) begin
            t_r     <= kn1_r + div_quo[T_W-1:0];
            st_r    <= 3'd0;
            crd_r   <= 1'b0;
            deg_r   <= 1'b0;
            state_r <= S_A;
          end
        end
        S_A: begin
          if (den == '0) begin
            // zero-length interval yields the left point
            rx_r[st_r] <= lx;
            ry_r[st_r] <= ly;
            deg_r      <= 1'b1;
            if (st_r == 3'd5) begin
              state_r <= S_OUT;
            end else begin
              st_r <= st_r + 3'd1;
            end
          end else begin
            m_r     <= mp;
            state_r <= S_B;
          end
        end
        S_B: begin
          state_r <= S_W;
        end
        S_W: begin
          if (div_done) begin
            if (!crd_r) begin
              rx_r[st_r] <= sat_coord(div_quo);
              crd_r      <= 1'b1;
              state_r    <= S_A;
            end else begin
              ry_r[st_r] <= sat_coord(div_quo);
              crd_r      <= 1'b0;
              if (st_r == 3'd5) begin
                state_r <= S_OUT;
              end else begin
                st_r    <= st_r + 3'd1;
                state_r <= S_A;
              end
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_r <= 1'b1;
            ox_r <= rx_r[5];
            oy_r <= ry_r[5];
            ol_r <= (i_r == job_r.n - N_W'(1));
            od_r <= deg_r;
            i_r  <= i_r + N_W'(1);
            state_r <= (i_r == job_r.n - N_W'(1)) ? S_IDLE : S_SMP;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/catmull_rom_chordal_interpolator.sv
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     in_point_x, in_point_y, in_new_curve
// out      output     out_valid / out_ready   out_x, out_y, out_last_of_run, out_degenerate
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a point that completes a window starts the chord work (three 29-step square
// roots); each emitted point then needs one knot division and up to twelve stage
// divisions on the shared serial divider. reset is synchronous and needs no
// clearing pass. a two-job queue lets input points keep arriving while a
// segment is computed; the input stalls only when the queue is full, the
// sequencer only while a held output is not yet taken.
module catmull_rom_chordal_interpolator import crci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_point_x,
  input  logic [COORD_W-1:0]   in_point_y,
  input  logic                 in_new_curve,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic                 out_last_of_run,
  output logic                 out_degenerate,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [N_W-1:0]       cfg_data
);

  crci_qstat_t q_stat;
  crci_job_t   wr_job;
  crci_job_t   rd_job;
  logic        q_push;
  logic        q_pop;

  assign cfg_ready = 1'b1;

  crci_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_new_curve (in_new_curve),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_job        (wr_job)
  );

  crci_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  crci_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_job           (rd_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_last_of_run (out_last_of_run),
    .out_degenerate  (out_degenerate)
  );

  // queue never overflows nor underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("job popped from an empty queue");

  a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty)) else $error("queue both full and empty");

  // a job pushed into an empty idle queue is not lost
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_stat.empty && !q_pop |=> !q_stat.empty)
    else $error("pushed job vanished");

endmodule

>>> sim/crci_checker.sv
// watches the point, result and register channels, predicts every
// interpolated point and compares it with what the block delivers
module crci_checker import crci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [COORD_W-1:0]   in_point_x,
  input  logic [COORD_W-1:0]   in_point_y,
  input  logic                 in_new_curve,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [COORD_W-1:0]   out_x,
  input  logic [COORD_W-1:0]   out_y,
  input  logic                 out_last_of_run,
  input  logic                 out_degenerate,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [N_W-1:0]       cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               degen;
  } curve_pt_t;

  curve_pt_t  exp_pts[$];

  // shadow of the block's window and registers
  longint     win_x[3];
  longint     win_y[3];
  int         held;
  logic [N_W-1:0] pps_reg;
  logic       en_reg;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // euclidean distance in 17.12, rounded down
  function automatic longint chord_len(longint ax, longint ay, longint bx, longint by);
    longint          dx;
    longint          dy;
    longint unsigned s;
    dx = bx - ax;
    dy = by - ay;
    s  = longint'(dx * dx) + longint'(dy * dy);
    return longint'(int_sqrt(s << 24));
  endfunction

  // nearest, ties to even, den positive
  function automatic longint round_div(longint num, longint den);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    if (r < 0) begin
      q = q - 1;
      r = r + den;
    end
    if (2 * r > den || (2 * r == den && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one linear blend of the pyramid
  function automatic void blend(input longint t, input longint ti, input longint tj,
                                input longint lx, input longint ly,
                                input longint rx, input longint ry,
                                output longint ox, output longint oy, inout bit deg);
    longint den;
    den = tj - ti;
    if (den <= 0) begin
      deg = 1'b1;
      ox  = lx;
      oy  = ly;
    end else begin
      ox = sat16(round_div((tj - t) * lx + (t - ti) * rx, den));
      oy = sat16(round_div((tj - t) * ly + (t - ti) * ry, den));
    end
  endfunction

  // expected run for one control point that completes a window
  task automatic predict_segment(longint nx, longint ny);
    longint    t1, t2, t3, n, t;
    longint    a1x, a1y, a2x, a2y, a3x, a3y, b1x, b1y, b2x, b2y, cx, cy;
    bit        deg;
    curve_pt_t e;
    t1 = chord_len(win_x[0], win_y[0], win_x[1], win_y[1]);
    t2 = t1 + chord_len(win_x[1], win_y[1], win_x[2], win_y[2]);
    t3 = t2 + chord_len(win_x[2], win_y[2], nx, ny);
    n  = longint'(pps_reg);
    if (n < 2) n = 2;
    if (n > MAX_PPS) n = MAX_PPS;
    for (longint i = 0; i < n; i++) begin
      deg = 1'b0;
      t   = t1 + (i * (t2 - t1)) / (n - 1);
      blend(t, 0, t1, win_x[0], win_y[0], win_x[1], win_y[1], a1x, a1y, deg);
      blend(t, t1, t2, win_x[1], win_y[1], win_x[2], win_y[2], a2x, a2y, deg);
      blend(t, t2, t3, win_x[2], win_y[2], nx, ny, a3x, a3y, deg);
      blend(t, 0, t2, a1x, a1y, a2x, a2y, b1x, b1y, deg);
      blend(t, t1, t3, a2x, a2y, a3x, a3y, b2x, b2y, deg);
      blend(t, t1, t2, b1x, b1y, b2x, b2y, cx, cy, deg);
      e.x     = cx[COORD_W-1:0];
      e.y     = cy[COORD_W-1:0];
      e.last  = (i == n - 1);
      e.degen = deg;
      exp_pts.insert(exp_pts.size(), e);
    end
  endtask

  // compare results, predict accepted points, track registers
  always @(posedge clk) begin
    curve_pt_t e;
    longint    nx;
    longint    ny;
    if (!rst_n) begin
      held    = 0;
      pps_reg = 7'd8;
      en_reg  = 1'b1;
      exp_pts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (exp_pts.size() == 0) begin
          $display("%0t unexpected item x %0d y %0d", $time, $signed(out_x), $signed(out_y));
          fail_count++;
        end else begin
          e = exp_pts.pop_front();
          if (out_x !== e.x) begin
            $display("%0t out_x expected %0d actual %0d", $time, $signed(e.x), $signed(out_x));
            fail_count++;
          end
          if (out_y !== e.y) begin
            $display("%0t out_y expected %0d actual %0d", $time, $signed(e.y), $signed(out_y));
            fail_count++;
          end
          if (out_last_of_run !== e.last) begin
            $display("%0t out_last_of_run expected %0b actual %0b", $time, e.last,
                     out_last_of_run);
            fail_count++;
          end
          if (out_degenerate !== e.degen) begin
            $display("%0t out_degenerate expected %0b actual %0b", $time, e.degen,
                     out_degenerate);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        nx = longint'($signed(in_point_x));
        ny = longint'($signed(in_point_y));
        if (in_new_curve) held = 0;
        if (held >= 3 && en_reg) predict_segment(nx, ny);
        win_x[0] = win_x[1];
        win_y[0] = win_y[1];
        win_x[1] = win_x[2];
        win_y[1] = win_y[2];
        win_x[2] = nx;
        win_y[2] = ny;
        if (held < 3) held++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PPS) pps_reg = cfg_data;
        else if (cfg_index == REG_EN) en_reg = cfg_data[0];
      end
    end
    pending = exp_pts.size();
  end

endmodule

>>> sim/tb_catmull_rom_chordal_interpolator.sv
// stimulus and verdict for the chordal catmull-rom interpolator
module tb_catmull_rom_chordal_interpolator;
  import crci_pkg::*;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   in_point_x = '0;
  logic [COORD_W-1:0]   in_point_y = '0;
  logic                 in_new_curve = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_x;
  logic [COORD_W-1:0]   out_y;
  logic                 out_last_of_run;
  logic                 out_degenerate;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [N_W-1:0]       cfg_data = '0;
  int                   fail_count;
  int                   pending;

  bit                   hold_req = 1'b0;
  longint               px = 0;
  longint               py = 0;

  catmull_rom_chordal_interpolator u_top (.*);

  crci_checker u_chk (.*);

  always #10 clk = ~clk;

  // overall time limit
  initial begin
    #2_000_000_000;
    $display("catmull_rom_chordal_interpolator: mismatch");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int  idle_left;
    int  free_left;
    int  r;
    bit  held_long;
    idle_left = 0;
    free_left = 0;
    held_long = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !held_long) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (8000) @(posedge clk);
      end else if (free_left > 0) begin
        free_left--;
        out_ready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
        end else if (r < 92) begin
          out_ready <= 1'b0;
          idle_left = $urandom_range(0, 3);
        end else if (r < 97) begin
          out_ready <= 1'b0;
          idle_left = $urandom_range(20, 120);
        end else begin
          out_ready <= 1'b1;
          free_left = $urandom_range(100, 400);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  task automatic send_point(longint x, longint y, bit nc);
    int gap;
    in_valid     <= 1'b1;
    in_point_x   <= x[COORD_W-1:0];
    in_point_y   <= y[COORD_W-1:0];
    in_new_curve <= nc;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all results, then let any trailing window work settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[N_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint next_coord(longint prev);
    int     r;
    longint v;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      v = prev + longint'($urandom_range(0, 400)) - 200;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else if (r < 82) begin
      v = longint'($signed(16'($urandom)));
    end else if (r < 93) begin
      v = prev;
    end else begin
      v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    end
    return v;
  endfunction

  task automatic send_random(bit nc);
    px = next_coord(px);
    py = next_coord(py);
    send_point(px, py, nc);
  endtask

  // stimulus
  initial begin
    int  left;
    int  count;
    int  n_items;
    int  phase;
    bit  nc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short runs, extremes, coincident points
    write_reg(REG_PPS, 2);
    write_reg(REG_EN, 1);
    send_point(0, 0, 1);
    send_point(10, 0, 0);
    send_point(20, 5, 0);
    send_point(30, 0, 0);
    send_point(-32768, -32768, 1);
    send_point(32767, 32767, 0);
    send_point(-32768, 32767, 0);
    send_point(32767, -32768, 0);
    send_point(5, 5, 1);
    send_point(5, 5, 0);
    send_point(5, 5, 0);
    send_point(5, 5, 0);
    send_point(1, 1, 1);
    send_point(1, 1, 0);
    send_point(9, 9, 0);
    send_point(20, 3, 0);
    wait_idle();
    // run lengths below and above the legal range
    write_reg(REG_PPS, 0);
    send_point(40, -7, 0);
    wait_idle();
    write_reg(REG_PPS, 1);
    send_point(-100, 300, 0);
    wait_idle();
    write_reg(REG_PPS, 127);
    send_point(1000, -2000, 0);
    wait_idle();
    write_reg(REG_PPS, 64);
    send_point(-5000, 12000, 0);
    wait_idle();
    // disabled: window still advances
    write_reg(REG_EN, 0);
    send_point(7, 8, 0);
    send_point(-9, 10, 0);
    wait_idle();
    write_reg(REG_SPARE_A, 127);
    write_reg(REG_SPARE_B, 0);
    write_reg(REG_EN, 1);
    write_reg(REG_PPS, 3);
    send_point(11, -12, 0);
    wait_idle();

    // random phases of well-formed curves with some noise
    n_items = 0;
    phase = 0;
    while (n_items < 430) begin
      if (phase % 5 == 4) begin
        write_reg(REG_PPS, ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(65, 127));
        count = 4;
      end else begin
        if ($urandom_range(0, 9) == 0) write_reg(REG_PPS, $urandom_range(0, 1));
        else write_reg(REG_PPS, $urandom_range(2, 5));
        count = 40;
      end
      // the hold-off phase always interpolates so the block backs up
      write_reg(REG_EN, (phase != 0 && $urandom_range(0, 7) == 0) ? 0 : 1);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'(REG_SPARE_A + $urandom_range(0, 1)), $urandom);
      end
      left = 0;
      for (int k = 0; k < count; k++) begin
        if (phase == 0 && k == 10) hold_req = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          nc = $urandom_range(0, 1);
        end else if (left == 0) begin
          nc = 1'b1;
          left = $urandom_range(4, 12);
        end else begin
          nc = 1'b0;
        end
        if (left > 0) left--;
        send_random(nc);
      end
      n_items += count;
      phase++;
      wait_idle();
    end

    // final drain and verdict
    wait_idle();
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("catmull_rom_chordal_interpolator: match");
    end else begin
      $display("catmull_rom_chordal_interpolator: mismatch");
    end
    $finish;
  end

endmodule
